// File: rtl/core/tcw_pkg.sv
// Shared types and constants for the text console cell writer.
package tcw_pkg;

    localparam int SCREEN_COLUMNS_DEF = 80;
    localparam int SCREEN_ROWS_DEF    = 25;

    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int COLUMN_W = 7;
    localparam int ROW_W    = 5;

    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CODE_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CODE_LINE_FEED = 8'h0A;
    localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'h0D;

    localparam logic [COLUMN_W:0] TAB_STEP   = 8'd8;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    typedef struct packed {
        logic                cell_write;
        logic [INDEX_W-1:0]  cell_index;
        logic [CHAR_W-1:0]   cell_char;
        logic [ATTR_W-1:0]   cell_attr;
        logic                clear_screen;
        logic [COLUMN_W-1:0] cursor_column;
        logic [ROW_W-1:0]    cursor_row;
        logic [INDEX_W-1:0]  cursor_offset;
    } t_result;

endpackage

// File: rtl/core/text_console_cell_writer.sv
// Input register, output register; the cursor update is a single registered pass.
// Throughput: one word per cycle while the output is not stalled.
// The input stage advances whenever the output register is empty or being taken.
// Reset (synchronous, active low): cursor homed, attribute set to 0x07,
// both stages emptied.
module text_console_cell_writer #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]     i_cfg_cell_attribute,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_cell_write,
    output logic [tcw_pkg::INDEX_W-1:0]    o_cell_index,
    output logic [tcw_pkg::CHAR_W-1:0]     o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]     o_cell_attr,
    output logic                           o_clear_screen,
    output logic [tcw_pkg::COLUMN_W-1:0]   o_cursor_column,
    output logic [tcw_pkg::ROW_W-1:0]      o_cursor_row,
    output logic [tcw_pkg::INDEX_W-1:0]    o_cursor_offset
);

    logic                        r_in_valid;
    logic [tcw_pkg::CHAR_W-1:0]  r_char;
    logic [tcw_pkg::ATTR_W-1:0]  r_attr;
    logic                        r_out_valid;
    tcw_pkg::t_result            r_res;
    tcw_pkg::t_result            n_res;

    logic out_free;
    logic step;
    logic take_in;

    assign out_free    = !r_out_valid || !i_stall;
    assign step        = r_in_valid && out_free;
    assign o_stall     = r_in_valid && !out_free;
    assign take_in     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    tcw_cursor #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_char_code (r_char),
        .i_attr      (r_attr),
        .o_result    (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_attr      <= tcw_pkg::ATTR_RESET;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_attr <= i_cfg_cell_attribute;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_char <= i_char_code;
        end
        if (step) begin
            r_res <= n_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cell_write    = r_res.cell_write;
    assign o_cell_index    = r_res.cell_index;
    assign o_cell_char     = r_res.cell_char;
    assign o_cell_attr     = r_res.cell_attr;
    assign o_clear_screen  = r_res.clear_screen;
    assign o_cursor_column = r_res.cursor_column;
    assign o_cursor_row    = r_res.cursor_row;
    assign o_cursor_offset = r_res.cursor_offset;

endmodule

// File: rtl/core/tcw_cursor.sv
// Cursor registers and per-character cursor and cell update logic.
module tcw_cursor #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [tcw_pkg::CHAR_W-1:0]    i_char_code,
    input  logic [tcw_pkg::ATTR_W-1:0]    i_attr,
    output tcw_pkg::t_result              o_result
);

    localparam int CW = tcw_pkg::COLUMN_W;
    localparam int RW = tcw_pkg::ROW_W;
    localparam int PW = tcw_pkg::INDEX_W + 1;

    localparam logic [CW:0]   COLS_LIM = (CW+1)'(SCREEN_COLUMNS);
    localparam logic [RW:0]   ROWS_LIM = (RW+1)'(SCREEN_ROWS);
    localparam logic [PW-1:0] COLS_MUL = PW'(SCREEN_COLUMNS);

    logic [CW-1:0] r_column, n_column;
    logic [RW-1:0] r_row, n_row;

    logic [CW:0]   col_sum;
    logic [RW:0]   row_sum;
    logic          wrote;
    logic          clear;
    logic [PW-1:0] w_index;
    logic [PW-1:0] c_offset;

    always_comb begin
        col_sum = {1'b0, r_column};
        row_sum = {1'b0, r_row};
        wrote   = 1'b0;
        case (i_char_code)
            tcw_pkg::CODE_BACKSPACE: begin
                if (r_column != '0) begin
                    col_sum = {1'b0, r_column} - (CW+1)'(1);
                end
            end
            tcw_pkg::CODE_TAB: begin
                col_sum = {1'b0, r_column} + tcw_pkg::TAB_STEP;
            end
            tcw_pkg::CODE_RETURN: begin
                col_sum = '0;
            end
            tcw_pkg::CODE_LINE_FEED: begin
                col_sum = '0;
                row_sum = {1'b0, r_row} + (RW+1)'(1);
            end
            default: begin
                wrote   = 1'b1;
                col_sum = {1'b0, r_column} + (CW+1)'(1);
            end
        endcase

        if (col_sum >= COLS_LIM) begin
            col_sum = '0;
            row_sum = row_sum + (RW+1)'(1);
        end
        clear = 1'b0;
        if (row_sum >= ROWS_LIM) begin
            clear   = 1'b1;
            col_sum = '0;
            row_sum = '0;
        end

        n_column = col_sum[CW-1:0];
        n_row    = row_sum[RW-1:0];

        w_index  = PW'(r_row) * COLS_MUL + PW'(r_column);
        c_offset = PW'(n_row) * COLS_MUL + PW'(n_column);

        o_result.cell_write    = wrote;
        o_result.cell_index    = wrote ? w_index[tcw_pkg::INDEX_W-1:0] : '0;
        o_result.cell_char     = wrote ? i_char_code : '0;
        o_result.cell_attr     = wrote ? i_attr : '0;
        o_result.clear_screen  = clear;
        o_result.cursor_column = n_column;
        o_result.cursor_row    = n_row;
        o_result.cursor_offset = c_offset[tcw_pkg::INDEX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
        end else if (i_step) begin
            r_column <= n_column;
            r_row    <= n_row;
        end
    end

    a_column_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW+1)'(r_column) < COLS_LIM)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (RW+1)'(r_row) < ROWS_LIM)
        else $error("cursor row out of range");

    a_clear_homes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && clear |=> r_column == '0 && r_row == '0)
        else $error("screen clear did not home the cursor");

    a_step_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_column) && $stable(r_row))
        else $error("cursor moved without a word");

endmodule

// File: dv/text_console_cell_writer_test.sv
`timescale 1ns / 100ps
// Testbench for the text console cell writer: directed table and random words against a predictor.
module text_console_cell_writer_test;

    localparam int COLUMNS    = tcw_pkg::SCREEN_COLUMNS_DEF;
    localparam int ROWS       = tcw_pkg::SCREEN_ROWS_DEF;
    localparam int DEAD_LIMIT = 2000;
    localparam int HOLD_LEN   = 300;

    typedef struct {
        logic [tcw_pkg::CHAR_W-1:0] code;
        int                         reps;
        bit                         typed;
        tcw_pkg::t_result           want;
    } t_plan_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic                         o_stall;
    logic [tcw_pkg::CHAR_W-1:0]   i_char_code = '0;
    logic                         i_cfg_valid = 1'b0;
    logic                         o_cfg_ready;
    logic [tcw_pkg::ATTR_W-1:0]   i_cfg_cell_attribute = '0;
    logic                         o_valid;
    logic                         i_stall = 1'b0;
    logic                         o_cell_write;
    logic [tcw_pkg::INDEX_W-1:0]  o_cell_index;
    logic [tcw_pkg::CHAR_W-1:0]   o_cell_char;
    logic [tcw_pkg::ATTR_W-1:0]   o_cell_attr;
    logic                         o_clear_screen;
    logic [tcw_pkg::COLUMN_W-1:0] o_cursor_column;
    logic [tcw_pkg::ROW_W-1:0]    o_cursor_row;
    logic [tcw_pkg::INDEX_W-1:0]  o_cursor_offset;

    int                         cursor_col = 0;
    int                         cursor_row = 0;
    logic [tcw_pkg::ATTR_W-1:0] attr_now = tcw_pkg::ATTR_RESET;
    tcw_pkg::t_result           expected_cells[$];
    int                         fail_count = 0;
    int                         send_idle_pct = 0;
    int                         recv_idle_pct = 0;
    int                         holds_asked = 0;
    int                         holds_done = 0;
    int                         hold_left = 0;
    int                         dead_cycles = 0;
    t_plan_row                  plan[21];

    always #10 i_clk = ~i_clk;

    text_console_cell_writer uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_char_code          (i_char_code),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_cell_attribute (i_cfg_cell_attribute),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_cell_write         (o_cell_write),
        .o_cell_index         (o_cell_index),
        .o_cell_char          (o_cell_char),
        .o_cell_attr          (o_cell_attr),
        .o_clear_screen       (o_clear_screen),
        .o_cursor_column      (o_cursor_column),
        .o_cursor_row         (o_cursor_row),
        .o_cursor_offset      (o_cursor_offset)
    );

    function automatic tcw_pkg::t_result typed_cell(input int wr, input int idx, input int ch,
                                                    input int at, input int clr, input int col,
                                                    input int row, input int off);
        tcw_pkg::t_result r;
        r.cell_write    = 1'(wr);
        r.cell_index    = tcw_pkg::INDEX_W'(idx);
        r.cell_char     = tcw_pkg::CHAR_W'(ch);
        r.cell_attr     = tcw_pkg::ATTR_W'(at);
        r.clear_screen  = 1'(clr);
        r.cursor_column = tcw_pkg::COLUMN_W'(col);
        r.cursor_row    = tcw_pkg::ROW_W'(row);
        r.cursor_offset = tcw_pkg::INDEX_W'(off);
        return r;
    endfunction

    function automatic tcw_pkg::t_result next_cell(input logic [tcw_pkg::CHAR_W-1:0] code);
        tcw_pkg::t_result r;
        int col;
        int row;
        r = '0;
        col = cursor_col;
        row = cursor_row;
        case (code)
            tcw_pkg::CODE_BACKSPACE: begin
                if (col > 0) col = col - 1;
            end
            tcw_pkg::CODE_TAB: begin
                col = col + int'(tcw_pkg::TAB_STEP);
            end
            tcw_pkg::CODE_RETURN: begin
                col = 0;
            end
            tcw_pkg::CODE_LINE_FEED: begin
                col = 0;
                row = row + 1;
            end
            default: begin
                r.cell_write = 1'b1;
                r.cell_index = tcw_pkg::INDEX_W'(row * COLUMNS + col);
                r.cell_char  = code;
                r.cell_attr  = attr_now;
                col = col + 1;
            end
        endcase
        if (col >= COLUMNS) begin
            col = 0;
            row = row + 1;
        end
        if (row >= ROWS) begin
            r.clear_screen = 1'b1;
            col = 0;
            row = 0;
        end
        cursor_col = col;
        cursor_row = row;
        r.cursor_column = tcw_pkg::COLUMN_W'(col);
        r.cursor_row    = tcw_pkg::ROW_W'(row);
        r.cursor_offset = tcw_pkg::INDEX_W'(row * COLUMNS + col);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [tcw_pkg::INDEX_W-1:0] want_v,
                               input logic [tcw_pkg::INDEX_W-1:0] got_v);
        if (got_v !== want_v) begin
            fail_count++;
            $display("%0t: %s expected %0h got %0h", $time, field, want_v, got_v);
        end
    endtask

    task automatic send_char(input logic [tcw_pkg::CHAR_W-1:0] code, input bit typed,
                             input tcw_pkg::t_result want);
        tcw_pkg::t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_code <= code;
        do @(posedge i_clk); while (o_stall);
        predicted = next_cell(code);
        expected_cells.push_back(typed ? want : predicted);
    endtask

    task automatic drain;
        while (expected_cells.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [tcw_pkg::ATTR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_cell_attribute <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        attr_now = value;
    endtask

    task automatic run_random(input int count, input int hold_at);
        int pick;
        logic [tcw_pkg::CHAR_W-1:0] code;
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) holds_asked++;
            pick = $urandom_range(99);
            if (pick < 10) code = tcw_pkg::CODE_LINE_FEED;
            else if (pick < 16) code = tcw_pkg::CODE_TAB;
            else if (pick < 21) code = tcw_pkg::CODE_BACKSPACE;
            else if (pick < 25) code = tcw_pkg::CODE_RETURN;
            else code = tcw_pkg::CHAR_W'($urandom_range(255));
            send_char(code, 1'b0, '0);
        end
        i_valid <= 1'b0;
    endtask

    // receiver side: random stall, long hold-off on request
    always @(posedge i_clk) begin
        if (holds_asked != holds_done) begin
            holds_done = holds_asked;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        tcw_pkg::t_result got;
        tcw_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_cell_write, o_cell_index, o_cell_char, o_cell_attr, o_clear_screen,
                   o_cursor_column, o_cursor_row, o_cursor_offset};
            if (expected_cells.size() == 0) begin
                fail_count++;
                $display("%0t: expected no word got %h", $time, got);
            end else begin
                want = expected_cells.pop_front();
                check_field("cell_write", 11'(want.cell_write), 11'(got.cell_write));
                check_field("cell_index", want.cell_index, got.cell_index);
                check_field("cell_char", 11'(want.cell_char), 11'(got.cell_char));
                check_field("cell_attr", 11'(want.cell_attr), 11'(got.cell_attr));
                check_field("clear_screen", 11'(want.clear_screen), 11'(got.clear_screen));
                check_field("cursor_column", 11'(want.cursor_column),
                            11'(got.cursor_column));
                check_field("cursor_row", 11'(want.cursor_row), 11'(got.cursor_row));
                check_field("cursor_offset", want.cursor_offset, got.cursor_offset);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            dead_cycles = 0;
        end else begin
            dead_cycles = dead_cycles + 1;
            if (dead_cycles >= DEAD_LIMIT) begin
                $display("FAIL text_console_cell_writer");
                $finish;
            end
        end
    end

    initial begin
        plan = '{
            '{tcw_pkg::CODE_BACKSPACE, 1, 1'b1, typed_cell(0, 0, 0, 0, 0, 0, 0, 0)},
            '{8'h00, 1, 1'b1, typed_cell(1, 0, 8'h00, 8'h07, 0, 1, 0, 1)},
            '{8'hFF, 1, 1'b1, typed_cell(1, 1, 8'hFF, 8'h07, 0, 2, 0, 2)},
            '{tcw_pkg::CODE_BACKSPACE, 1, 1'b1, typed_cell(0, 0, 0, 0, 0, 1, 0, 1)},
            '{tcw_pkg::CODE_TAB, 1, 1'b1, typed_cell(0, 0, 0, 0, 0, 9, 0, 9)},
            '{tcw_pkg::CODE_RETURN, 1, 1'b1, typed_cell(0, 0, 0, 0, 0, 0, 0, 0)},
            '{tcw_pkg::CODE_LINE_FEED, 1, 1'b1, typed_cell(0, 0, 0, 0, 0, 0, 1, 80)},
            '{tcw_pkg::CODE_TAB, 9, 1'b0, tcw_pkg::t_result'('0)},
            '{8'h41, 7, 1'b0, tcw_pkg::t_result'('0)},
            '{tcw_pkg::CODE_TAB, 1, 1'b1, typed_cell(0, 0, 0, 0, 0, 0, 2, 160)},
            '{tcw_pkg::CODE_LINE_FEED, 22, 1'b0, tcw_pkg::t_result'('0)},
            '{tcw_pkg::CODE_LINE_FEED, 1, 1'b1, typed_cell(0, 0, 0, 0, 1, 0, 0, 0)},
            '{tcw_pkg::CODE_LINE_FEED, 24, 1'b0, tcw_pkg::t_result'('0)},
            '{tcw_pkg::CODE_TAB, 9, 1'b0, tcw_pkg::t_result'('0)},
            '{tcw_pkg::CODE_TAB, 1, 1'b1, typed_cell(0, 0, 0, 0, 1, 0, 0, 0)},
            '{tcw_pkg::CODE_LINE_FEED, 24, 1'b0, tcw_pkg::t_result'('0)},
            '{tcw_pkg::CODE_TAB, 9, 1'b0, tcw_pkg::t_result'('0)},
            '{8'h20, 7, 1'b0, tcw_pkg::t_result'('0)},
            '{8'h80, 1, 1'b1, typed_cell(1, 1999, 8'h80, 8'h07, 1, 0, 0, 0)},
            '{tcw_pkg::CODE_RETURN, 1, 1'b1, typed_cell(0, 0, 0, 0, 0, 0, 0, 0)},
            '{8'h7A, 1, 1'b1, typed_cell(1, 0, 8'h7A, 8'h07, 0, 1, 0, 1)}
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 8;
        recv_idle_pct = 85;
        foreach (plan[i])
            for (int k = 0; k < plan[i].reps; k++)
                send_char(plan[i].code, plan[i].typed, plan[i].want);
        i_valid <= 1'b0;
        drain();
        write_attribute(8'h00);
        run_random(160, -1);

        drain();
        send_idle_pct = 85;
        recv_idle_pct = 8;
        write_attribute(8'hFF);
        run_random(160, -1);

        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_attribute(tcw_pkg::ATTR_W'($urandom_range(255)));
        run_random(160, 60);

        drain();
        if (fail_count == 0) begin
            $display("PASS text_console_cell_writer");
        end else begin
            $display("FAIL text_console_cell_writer");
        end
        $finish;
    end

endmodule
